// ===== rtl/cwts_pkg.sv =====
package cwts_pkg;

   // Default widths of the internal counters.
   localparam int COUNT_WIDTH_DEF  = 16;
   localparam int PERIOD_WIDTH_DEF = 24;

   // Fixed widths of the configuration registers and the result fields.
   localparam int WIND_PERIOD_W = 24;
   localparam int MOVE_HALF_W   = 16;
   localparam int PULSE_W       = 9;
   localparam int CFG_COUNT_W   = 16;
   localparam int OUT_COUNT_W   = 16;
   localparam int PHASE_W       = 3;
   localparam int CAUSE_W       = 2;

   // Configuration port.
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 24;

   localparam logic [CSR_INDEX_W-1:0] REG_WIND_PERIOD = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_MOVE_HALF   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_PULSES_STEP = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_OFFSET      = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_STEPS_TURN  = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_TURNS_LAYER = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_TOTAL_TURNS = 3'd6;

   // Register values after reset.
   localparam logic [WIND_PERIOD_W-1:0] WIND_PERIOD_RST = 24'd1000;
   localparam logic [MOVE_HALF_W-1:0]   MOVE_HALF_RST   = 16'd78;
   localparam logic [PULSE_W-1:0]       PULSES_STEP_RST = 9'd1;
   localparam logic [CFG_COUNT_W-1:0]   OFFSET_RST      = 16'd0;
   localparam logic [CFG_COUNT_W-1:0]   STEPS_TURN_RST  = 16'd1;
   localparam logic [CFG_COUNT_W-1:0]   TURNS_LAYER_RST = 16'd1;
   localparam logic [CFG_COUNT_W-1:0]   TOTAL_TURNS_RST = 16'd0;

   // Sequencer phase, as shown on the result channel.
   typedef enum logic [PHASE_W-1:0] {
      PH_IDLE   = 3'd0,
      PH_HOME   = 3'd1,
      PH_OFFSET = 3'd2,
      PH_WIND   = 3'd3,
      PH_DONE   = 3'd4
   } phase_type;

   // Reason the last run stopped.
   typedef enum logic [CAUSE_W-1:0] {
      CAUSE_NONE  = 2'd0,
      CAUSE_TURNS = 2'd1,
      CAUSE_LIMIT = 2'd2,
      CAUSE_DOOR  = 2'd3
   } cause_type;

   typedef struct packed {
      logic [WIND_PERIOD_W-1:0] winding_pulse_period;
      logic [MOVE_HALF_W-1:0]   move_half_period;
      logic [PULSE_W-1:0]       pulses_per_step;
      logic [CFG_COUNT_W-1:0]   offset_steps;
      logic [CFG_COUNT_W-1:0]   steps_per_turn;
      logic [CFG_COUNT_W-1:0]   turns_per_layer;
      logic [CFG_COUNT_W-1:0]   total_turns;
   } cfg_type;

   typedef struct packed {
      logic start_req;
      logic home_released;
      logic door_open;
   } req_type;

   typedef struct packed {
      logic                   step_out;
      logic                   dir_out;
      logic                   driver_enable_n;
      logic                   spindle_on;
      logic [PHASE_W-1:0]     phase;
      logic [OUT_COUNT_W-1:0] turns_done;
      logic [OUT_COUNT_W-1:0] layer_now;
      logic [CAUSE_W-1:0]     stop_cause;
   } rsp_type;

endpackage

// ===== rtl/cwts_if.sv =====
// Tick channel into the sequencer.
interface cwts_req_if;
   import cwts_pkg::*;

   logic valid;
   logic ready;
   logic start_req;
   logic home_released;
   logic door_open;

   modport source (output valid, output start_req, output home_released,
                   output door_open, input ready);
   modport sink (input valid, input start_req, input home_released,
                 input door_open, output ready);
endinterface

// Result channel out of the sequencer.
interface cwts_rsp_if;
   import cwts_pkg::*;

   logic                   valid;
   logic                   ready;
   logic                   step_out;
   logic                   dir_out;
   logic                   driver_enable_n;
   logic                   spindle_on;
   logic [PHASE_W-1:0]     phase;
   logic [OUT_COUNT_W-1:0] turns_done;
   logic [OUT_COUNT_W-1:0] layer_now;
   logic [CAUSE_W-1:0]     stop_cause;

   modport source (output valid, output step_out, output dir_out,
                   output driver_enable_n, output spindle_on, output phase,
                   output turns_done, output layer_now, output stop_cause,
                   input ready);
   modport sink (input valid, input step_out, input dir_out,
                 input driver_enable_n, input spindle_on, input phase,
                 input turns_done, input layer_now, input stop_cause,
                 output ready);
endinterface

// Register write channel.
interface cwts_csr_if;
   import cwts_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/coil_winder_traverse_sequencer.sv =====
// Traverse sequencer for a coil winder.
// req_ch carries one transaction per microsecond tick with the start request,
// the home switch level and the door switch. rsp_ch returns one transaction
// per tick with the step line, direction, driver enable, spindle enable, phase,
// turn and layer counts and stop cause, all as they stand after that tick.
// csr_ch writes the seven configuration registers by index; it is always
// ready and must only be used while no tick is in flight.
// A tick passes the input register and then the result register.
// Throughput: one tick per cycle while rsp_ch does not stall; the phase logic
// between the two registers is combinational.
// Reset sets the phase to idle, clears the turn, step and pulse counters, sets
// the layer count to one, clears rsp_ch valid and loads the register defaults.
// When rsp_ch stalls, the finished result holds, one more tick waits in the
// input register, and req_ch drops ready until the result is taken.
module coil_winder_traverse_sequencer #(
   parameter int COUNT_WIDTH  = cwts_pkg::COUNT_WIDTH_DEF,
   parameter int PERIOD_WIDTH = cwts_pkg::PERIOD_WIDTH_DEF
) (
   input logic        clock,
   input logic        reset,
   cwts_req_if.sink   req_ch,
   cwts_rsp_if.source rsp_ch,
   cwts_csr_if.sink   csr_ch
);
   import cwts_pkg::*;

   cfg_type cfg;
   rsp_type core_result;

   logic    in_valid_ff, in_valid_in;
   req_type in_item_ff;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff;

   logic    req_take;
   logic    advance;

   cwts_csr u_csr (
      .clock (clock),
      .reset (reset),
      .csr   (csr_ch),
      .cfg   (cfg)
   );

   cwts_core #(
      .COUNT_WIDTH  (COUNT_WIDTH),
      .PERIOD_WIDTH (PERIOD_WIDTH)
   ) u_core (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (in_item_ff),
      .cfg     (cfg),
      .result  (core_result)
   );

   // The held tick moves on when the result register is free or being emptied.
   assign advance      = in_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || advance;
   assign req_take     = req_ch.valid && req_ch.ready;

   always_comb begin
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end

      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Handshake state.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_item_ff.start_req     <= req_ch.start_req;
         in_item_ff.home_released <= req_ch.home_released;
         in_item_ff.door_open     <= req_ch.door_open;
      end
      if (advance) begin
         rsp_data_ff <= core_result;
      end
   end

   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.step_out        = rsp_data_ff.step_out;
   assign rsp_ch.dir_out         = rsp_data_ff.dir_out;
   assign rsp_ch.driver_enable_n = rsp_data_ff.driver_enable_n;
   assign rsp_ch.spindle_on      = rsp_data_ff.spindle_on;
   assign rsp_ch.phase           = rsp_data_ff.phase;
   assign rsp_ch.turns_done      = rsp_data_ff.turns_done;
   assign rsp_ch.layer_now       = rsp_data_ff.layer_now;
   assign rsp_ch.stop_cause      = rsp_data_ff.stop_cause;

endmodule

// ===== rtl/cwts_csr.sv =====
module cwts_csr (
   input  logic             clock,
   input  logic             reset,
   cwts_csr_if.sink         csr,
   output cwts_pkg::cfg_type cfg
);
   import cwts_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Writes are always taken; an unknown index is dropped.
   assign csr.ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr.valid) begin
         unique case (csr.index)
            REG_WIND_PERIOD: cfg_in.winding_pulse_period = csr.data[WIND_PERIOD_W-1:0];
            REG_MOVE_HALF:   cfg_in.move_half_period     = csr.data[MOVE_HALF_W-1:0];
            REG_PULSES_STEP: cfg_in.pulses_per_step      = csr.data[PULSE_W-1:0];
            REG_OFFSET:      cfg_in.offset_steps         = csr.data[CFG_COUNT_W-1:0];
            REG_STEPS_TURN:  cfg_in.steps_per_turn       = csr.data[CFG_COUNT_W-1:0];
            REG_TURNS_LAYER: cfg_in.turns_per_layer      = csr.data[CFG_COUNT_W-1:0];
            REG_TOTAL_TURNS: cfg_in.total_turns          = csr.data[CFG_COUNT_W-1:0];
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.winding_pulse_period <= WIND_PERIOD_RST;
         cfg_ff.move_half_period     <= MOVE_HALF_RST;
         cfg_ff.pulses_per_step      <= PULSES_STEP_RST;
         cfg_ff.offset_steps         <= OFFSET_RST;
         cfg_ff.steps_per_turn       <= STEPS_TURN_RST;
         cfg_ff.turns_per_layer      <= TURNS_LAYER_RST;
         cfg_ff.total_turns          <= TOTAL_TURNS_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== rtl/cwts_core.sv =====
module cwts_core #(
   parameter int COUNT_WIDTH  = cwts_pkg::COUNT_WIDTH_DEF,
   parameter int PERIOD_WIDTH = cwts_pkg::PERIOD_WIDTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  cwts_pkg::req_type item,
   input  cwts_pkg::cfg_type cfg,
   output cwts_pkg::rsp_type result
);
   import cwts_pkg::*;

   // Compare widths wide enough for both a counter and its register.
   localparam int TCMP_W = (PERIOD_WIDTH > WIND_PERIOD_W) ? PERIOD_WIDTH : WIND_PERIOD_W;
   localparam int CCMP_W = (COUNT_WIDTH > CFG_COUNT_W) ? COUNT_WIDTH : CFG_COUNT_W;

   localparam logic [PERIOD_WIDTH-1:0] TICK_MAX  = '1;
   localparam logic [COUNT_WIDTH-1:0]  COUNT_MAX = '1;
   localparam logic [COUNT_WIDTH-1:0]  COUNT_ONE = COUNT_WIDTH'(1);

   phase_type               phase_ff, phase_in;
   cause_type               cause_ff, cause_in;
   logic [PERIOD_WIDTH-1:0] tick_ff, tick_in;
   logic [PULSE_W-1:0]      pulse_ff, pulse_in;
   logic [COUNT_WIDTH-1:0]  step_ff, step_in;
   logic [COUNT_WIDTH-1:0]  lturn_ff, lturn_in;
   logic [COUNT_WIDTH-1:0]  ttotal_ff, ttotal_in;
   logic [COUNT_WIDTH-1:0]  layer_ff, layer_in;
   logic                    dir_ff, dir_in;
   logic                    level_ff, level_in;

   logic [PERIOD_WIDTH-1:0] tick_inc;
   logic                    move_reached;
   logic                    wind_reached;
   logic [PULSE_W:0]        pulse_sum;
   logic                    pulse_wrap;
   logic [PULSE_W-1:0]      pulse_next;
   logic [COUNT_WIDTH-1:0]  step_next;
   logic [COUNT_WIDTH-1:0]  lturn_inc;
   logic [COUNT_WIDTH-1:0]  ttotal_inc;
   logic [COUNT_WIDTH-1:0]  layer_inc;

   // Saturating tick counter and the two period compares.
   always_comb begin
      tick_inc     = (tick_ff == TICK_MAX) ? tick_ff : tick_ff + 1'b1;
      move_reached = (TCMP_W'(tick_inc) >= TCMP_W'(cfg.move_half_period)) ||
                     (tick_inc == TICK_MAX);
      wind_reached = (TCMP_W'(tick_inc) >= TCMP_W'(cfg.winding_pulse_period)) ||
                     (tick_inc == TICK_MAX);
   end

   // Pulse-to-step counting and the saturating turn and layer increments.
   always_comb begin
      pulse_sum  = {1'b0, pulse_ff} + 1'b1;
      pulse_wrap = pulse_sum >= {1'b0, cfg.pulses_per_step};
      pulse_next = pulse_wrap ? '0 : pulse_sum[PULSE_W-1:0];
      if (pulse_wrap && (step_ff != COUNT_MAX)) begin
         step_next = step_ff + 1'b1;
      end else begin
         step_next = step_ff;
      end
      lturn_inc  = (lturn_ff == COUNT_MAX) ? lturn_ff : lturn_ff + 1'b1;
      ttotal_inc = (ttotal_ff == COUNT_MAX) ? ttotal_ff : ttotal_ff + 1'b1;
      layer_inc  = (layer_ff == COUNT_MAX) ? layer_ff : layer_ff + 1'b1;
   end

   // Next state for one tick.
   always_comb begin
      phase_in  = phase_ff;
      cause_in  = cause_ff;
      tick_in   = tick_ff;
      pulse_in  = pulse_ff;
      step_in   = step_ff;
      lturn_in  = lturn_ff;
      ttotal_in = ttotal_ff;
      layer_in  = layer_ff;
      dir_in    = dir_ff;
      level_in  = level_ff;

      unique case (phase_ff)
         PH_HOME, PH_OFFSET: begin
            tick_in = tick_inc;
            if (move_reached) begin
               if (level_ff) begin
                  // Falling edge of a move pulse counts it.
                  level_in = 1'b0;
                  tick_in  = '0;
                  pulse_in = pulse_next;
                  step_in  = step_next;
               end else if ((phase_ff == PH_HOME) && !item.home_released) begin
                  // Home reached: start the forward offset move.
                  phase_in = PH_OFFSET;
                  dir_in   = 1'b1;
                  pulse_in = '0;
                  step_in  = '0;
                  tick_in  = TICK_MAX;
                  level_in = 1'b0;
               end else if ((phase_ff == PH_OFFSET) &&
                            (CCMP_W'(step_ff) >= CCMP_W'(cfg.offset_steps))) begin
                  // Offset done: enter winding, or finish at once with no turns.
                  dir_in    = 1'b1;
                  pulse_in  = '0;
                  step_in   = '0;
                  tick_in   = TICK_MAX;
                  level_in  = 1'b0;
                  lturn_in  = '0;
                  ttotal_in = '0;
                  layer_in  = COUNT_ONE;
                  if (cfg.total_turns == '0) begin
                     phase_in = PH_DONE;
                     cause_in = CAUSE_TURNS;
                  end else begin
                     phase_in = PH_WIND;
                  end
               end else begin
                  level_in = 1'b1;
                  tick_in  = '0;
               end
            end
         end

         PH_WIND: begin
            level_in = 1'b0;
            tick_in  = tick_inc;
            if (wind_reached) begin
               tick_in  = '0;
               level_in = 1'b1;
               pulse_in = pulse_next;
               step_in  = step_next;
               if ((step_next != '0) &&
                   (CCMP_W'(step_next) >= CCMP_W'(cfg.steps_per_turn))) begin
                  // End of a turn.
                  step_in   = '0;
                  pulse_in  = '0;
                  ttotal_in = ttotal_inc;
                  if (CCMP_W'(lturn_inc) >= CCMP_W'(cfg.turns_per_layer)) begin
                     dir_in   = !dir_ff;
                     layer_in = layer_inc;
                     lturn_in = '0;
                  end else begin
                     lturn_in = lturn_inc;
                  end
                  // The limit switch wins over the door, the door over the count.
                  priority if (!item.home_released) begin
                     phase_in = PH_DONE;
                     cause_in = CAUSE_LIMIT;
                  end else if (item.door_open) begin
                     phase_in = PH_DONE;
                     cause_in = CAUSE_DOOR;
                  end else if (CCMP_W'(ttotal_inc) >= CCMP_W'(cfg.total_turns)) begin
                     phase_in = PH_DONE;
                     cause_in = CAUSE_TURNS;
                  end else begin
                     phase_in = PH_WIND;
                  end
               end
            end
         end

         default: begin
            // Idle or done: wait for a start request.
            level_in = 1'b0;
            if (item.start_req) begin
               cause_in  = CAUSE_NONE;
               ttotal_in = '0;
               layer_in  = COUNT_ONE;
               lturn_in  = '0;
               pulse_in  = '0;
               step_in   = '0;
               tick_in   = TICK_MAX;
               if (item.home_released) begin
                  phase_in = PH_HOME;
                  dir_in   = 1'b0;
               end else begin
                  phase_in = PH_OFFSET;
                  dir_in   = 1'b1;
               end
            end
         end
      endcase
   end

   // Result fields show the state after this tick.
   always_comb begin
      result.step_out        = level_in;
      result.dir_out         = dir_in;
      result.driver_enable_n = !((phase_in == PH_HOME) || (phase_in == PH_OFFSET) ||
                                 (phase_in == PH_WIND));
      result.spindle_on      = (phase_in == PH_WIND);
      result.phase           = phase_in;
      result.turns_done      = OUT_COUNT_W'(ttotal_in);
      result.layer_now       = OUT_COUNT_W'(layer_in);
      result.stop_cause      = cause_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         cause_ff  <= CAUSE_NONE;
         tick_ff   <= TICK_MAX;
         pulse_ff  <= '0;
         step_ff   <= '0;
         lturn_ff  <= '0;
         ttotal_ff <= '0;
         layer_ff  <= COUNT_ONE;
         dir_ff    <= 1'b1;
         level_ff  <= 1'b0;
      end else if (advance) begin
         phase_ff  <= phase_in;
         cause_ff  <= cause_in;
         tick_ff   <= tick_in;
         pulse_ff  <= pulse_in;
         step_ff   <= step_in;
         lturn_ff  <= lturn_in;
         ttotal_ff <= ttotal_in;
         layer_ff  <= layer_in;
         dir_ff    <= dir_in;
         level_ff  <= level_in;
      end
   end

endmodule
